@@ src/rmt_pkg.sv @@
// ----------------------------------------------------------------------------
// rmt_pkg: shared types and constants of the running median tracker
// Field widths of the stream payload, control state codes and the control
// group handed from the top level to the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package rmt_pkg;

  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned MEDIAN_W      = 17;
  localparam int unsigned COUNT_W       = 11;
  localparam int unsigned IN_TDATA_W    = 16;
  localparam int unsigned OUT_TDATA_W   = 32;
  localparam int unsigned CAPACITY_DEF  = 1024;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEL
  } state_e;

  // insert request broadcast to every cell of the row
  typedef struct packed {
    logic    ins;
    sample_t sample;
  } row_ctrl_t;

endpackage

`default_nettype wire

@@ src/rmt_cell.sv @@
// ----------------------------------------------------------------------------
// rmt_cell: one slot of the sorted sample row
// Holds one sample; on an insert it keeps its value, takes the new sample or
// takes the value of its lower neighbor, so the row stays sorted ascending.
// ----------------------------------------------------------------------------
`default_nettype none

module rmt_cell
  import rmt_pkg::*;
(
  input  wire logic      clk_i,
  input  wire row_ctrl_t ctrl_i,
  input  wire logic      beyond_i,    // slot at or past the fill level
  input  wire sample_t   prev_val_i,
  input  wire logic      prev_gt_i,
  output sample_t        val_o,
  output logic           gt_o
);

  sample_t val_q;
  sample_t val_d;

  // unfilled slots count as greater so the flag is monotone along the row
  assign gt_o  = beyond_i || (val_q > ctrl_i.sample);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins && gt_o) begin
      if (prev_gt_i) begin
        val_d = prev_val_i;
      end else begin
        val_d = ctrl_i.sample;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire

@@ src/rmt_row.sv @@
// ----------------------------------------------------------------------------
// rmt_row: chain of sorted sample cells
// CAPACITY cells wired neighbor to neighbor, plus the pick of the two middle
// cells for the median.
// ----------------------------------------------------------------------------
`default_nettype none

module rmt_row
  import rmt_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1),
  localparam int unsigned IDX_W   = $clog2(CAPACITY)
) (
  input  wire logic             clk_i,
  input  wire row_ctrl_t        ctrl_i,
  input  wire logic [CNT_W-1:0] count_i,
  input  wire logic [IDX_W-1:0] lo_idx_i,
  input  wire logic [IDX_W-1:0] hi_idx_i,
  output sample_t               lo_val_o,
  output sample_t               hi_val_o
);

  sample_t              val   [CAPACITY];
  logic    [CAPACITY-1:0] gt;
  logic    [CAPACITY-1:0] beyond;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sample_t prev_val;
    logic    prev_gt;

    assign beyond[i] = (count_i <= CNT_W'(i));

    if (i == 0) begin : g_first
      assign prev_val = ctrl_i.sample;
      assign prev_gt  = 1'b0;
    end else begin : g_rest
      assign prev_val = val[i-1];
      assign prev_gt  = gt[i-1];
    end

    rmt_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl_i),
      .beyond_i   (beyond[i]),
      .prev_val_i (prev_val),
      .prev_gt_i  (prev_gt),
      .val_o      (val[i]),
      .gt_o       (gt[i])
    );
  end

  assign lo_val_o = val[lo_idx_i];
  assign hi_val_o = val[hi_idx_i];

endmodule

`default_nettype wire

@@ src/running_median_tracker_top.sv @@
// ----------------------------------------------------------------------------
// running_median_tracker_top: running median over a signed sample stream
// Sorted cell row with a small request controller and an output register.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one 16-bit signed sample per request in tdata. Each
//   request yields exactly one result on m_axis: tdata holds twice the
//   median of all stored samples and the stored count, tuser flags a sample
//   that was refused because the store already held CAPACITY samples.
// Timing:
//   the accepting edge inserts the sample into the sorted cell row in one
//   step; in the select state the two middle cells are picked, added and
//   loaded into the output register once that register is free. No new
//   request is taken until the result of the last one has been loaded.
// Reset:
//   rst_ni clears the fill count and the handshake state; the cell contents
//   are not cleared, only filled slots are ever read.
// Stall:
//   a result waits in the output register while m_axis_tready_i is low; a
//   new request is still accepted and inserted, and its result waits until
//   the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module running_median_tracker_top
  import rmt_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // [15:0] sample
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,   // [16:0] median_doubled,
                                                        // [27:17] stored_count, rest 0
  output logic                        m_axis_tuser_o    // [0] dropped
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                drop_q, drop_d;
  logic                out_valid_q, out_valid_d;
  logic signed [MEDIAN_W-1:0] median_q, median_d;
  logic [COUNT_W-1:0]  out_count_q, out_count_d;
  logic                out_drop_q, out_drop_d;

  logic                accept;
  logic                full;
  logic                out_free;
  row_ctrl_t           row_ctrl;
  logic [CNT_W-1:0]    lo_pos, hi_pos;
  sample_t             lo_val, hi_val;

  assign full     = (count_q == CNT_W'(CAPACITY));
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign row_ctrl.ins    = accept && !full;
  assign row_ctrl.sample = sample_t'(s_axis_tdata_i[SAMPLE_W-1:0]);

  // middle positions of the sorted row for the updated count
  assign lo_pos = (count_q - CNT_W'(1)) >> 1;
  assign hi_pos = count_q >> 1;

  rmt_row #(
    .CAPACITY (CAPACITY)
  ) u_row (
    .clk_i    (clk_i),
    .ctrl_i   (row_ctrl),
    .count_i  (count_q),
    .lo_idx_i (lo_pos[IDX_W-1:0]),
    .hi_idx_i (hi_pos[IDX_W-1:0]),
    .lo_val_o (lo_val),
    .hi_val_o (hi_val)
  );

  always_comb begin
    state_d         = state_q;
    count_d         = count_q;
    drop_d          = drop_q;
    out_valid_d     = out_valid_q;
    median_d        = median_q;
    out_count_d     = out_count_q;
    out_drop_d      = out_drop_q;
    s_axis_tready_o = 1'b0;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          drop_d  = full;
          if (!full) begin
            count_d = count_q + CNT_W'(1);
          end
          state_d = ST_SEL;
        end
      end
      ST_SEL: begin
        if (out_free) begin
          median_d    = MEDIAN_W'(lo_val) + MEDIAN_W'(hi_val);
          out_count_d = COUNT_W'(count_q);
          out_drop_d  = drop_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    median_q    <= median_d;
    out_count_q <= out_count_d;
    out_drop_q  <= out_drop_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W - MEDIAN_W - COUNT_W){1'b0}},
                            out_count_q, median_q};
  assign m_axis_tuser_o  = out_drop_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !full |=> count_q == $past(count_q) + CNT_W'(1) && !drop_q)
    else $error("stored sample did not raise the fill count");

  a_drop_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && full |=> count_q == $past(count_q) && drop_q)
    else $error("refused sample changed the store");

  a_no_accept_in_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEL |-> !s_axis_tready_o)
    else $error("request taken while a median is pending");

endmodule

`default_nettype wire

@@ tb/tb_running_median_tracker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_running_median_tracker_top: stream test of the running median tracker
// Feeds signed samples in random bursts against a stalling receiver, tracks
// the stored multiset as two sorted halves, and checks every doubled median,
// stored count and refusal flag, including the refusals once the store fills.
// ----------------------------------------------------------------------------

module tb_running_median_tracker_top;
  import rmt_pkg::*;

  localparam int unsigned STORE_CAP    = CAPACITY_DEF;
  localparam int          RANDOM_ITEMS = 1530;
  localparam int          TAIL_CYCLES  = 8;
  localparam int          TIMEOUT_NS   = 10_000_000;

  typedef struct packed {
    logic signed [MEDIAN_W-1:0] median_doubled;
    logic [COUNT_W-1:0]         stored_count;
    logic                       dropped;
  } median_result_t;

  typedef enum int {
    SHAPE_UNIFORM,
    SHAPE_NARROW,
    SHAPE_RISING,
    SHAPE_FALLING,
    SHAPE_EXTREME
  } burst_shape_e;

  typedef enum int {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE,
    READY_EVERY_THIRD
  } ready_pattern_e;

  // keeps the stored multiset as two sorted halves and predicts each result
  class median_scoreboard;
    sample_t        lower_half[$];
    sample_t        upper_half[$];
    median_result_t expected_medians[$];
    int             mismatches;
    int             accepted;
    int             refused;
    int             checked;

    function void insert_sorted(ref sample_t half[$], input sample_t v);
      int pos;
      pos = half.size();
      while (pos > 0 && half[pos-1] > v) pos--;
      half.insert(pos, v);
    endfunction

    function void note_sample(sample_t x);
      median_result_t r;
      int             m;
      r.dropped = 1'b0;
      accepted++;
      if (lower_half.size() + upper_half.size() >= STORE_CAP) begin
        r.dropped = 1'b1;
        refused++;
      end else begin
        if (lower_half.size() == 0 || lower_half[$] > x) begin
          insert_sorted(lower_half, x);
        end else begin
          insert_sorted(upper_half, x);
        end
        // keep the halves within one element of each other
        if (lower_half.size() > upper_half.size() + 1) begin
          insert_sorted(upper_half, lower_half.pop_back());
        end else if (upper_half.size() > lower_half.size() + 1) begin
          insert_sorted(lower_half, upper_half.pop_front());
        end
      end
      if (lower_half.size() == upper_half.size()) begin
        m = int'(lower_half[$]) + int'(upper_half[0]);
      end else if (lower_half.size() < upper_half.size()) begin
        m = 2 * int'(upper_half[0]);
      end else begin
        m = 2 * int'(lower_half[$]);
      end
      r.median_doubled = m[MEDIAN_W-1:0];
      r.stored_count   = COUNT_W'(lower_half.size() + upper_half.size());
      expected_medians.insert(expected_medians.size(), r);
    endfunction

    function void check_result(median_result_t got);
      median_result_t want;
      checked++;
      if (expected_medians.size() == 0) begin
        $error("result with no request pending: median_doubled %0d, count %0d",
               got.median_doubled, got.stored_count);
        mismatches++;
        return;
      end
      want = expected_medians.pop_front();
      if (got.median_doubled !== want.median_doubled) begin
        $error("median_doubled mismatch: expected %0d, got %0d",
               want.median_doubled, got.median_doubled);
        mismatches++;
      end
      if (got.stored_count !== want.stored_count) begin
        $error("stored_count mismatch: expected %0d, got %0d",
               want.stored_count, got.stored_count);
        mismatches++;
      end
      if (got.dropped !== want.dropped) begin
        $error("dropped mismatch: expected %0d, got %0d", want.dropped, got.dropped);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_medians.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tready;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;

  median_scoreboard sb = new();

  ready_pattern_e ready_pattern = READY_ALWAYS;
  int             pattern_left = 0;
  int             cycle_count = 0;
  int             ramp_value = 0;

  sample_t directed_samples[20] = '{
    -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd0, -16'sd1, 16'sd1,
    16'sd0, 16'sd0, 16'sh5555, -16'sd21846, 16'sd100, 16'sd100, 16'sd100,
    -16'sd100, 16'sd32767, -16'sd32768, 16'sd12345, -16'sd12345, -16'sd32767
  };

  running_median_tracker_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver: stretches of random length, each with its own stall pattern
  always @(posedge clk_i) begin
    cycle_count++;
    if (pattern_left == 0) begin
      pattern_left  = $urandom_range(1, 48);
      ready_pattern = ready_pattern_e'($urandom_range(0, 3));
    end
    pattern_left--;
    case (ready_pattern)
      READY_ALWAYS: m_tready <= 1'b1;
      READY_HALF:   m_tready <= ($urandom_range(0, 1) == 1);
      READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
      default:      m_tready <= (cycle_count % 3 != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      sb.check_result(median_result_t'({m_tdata[MEDIAN_W-1:0],
                                        m_tdata[MEDIAN_W +: COUNT_W], m_tuser}));
    end
  end

  task automatic send_sample(sample_t x);
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sb.note_sample(x);
  endtask

  task automatic idle_cycles(int n);
    if (n == 0) return;
    s_tvalid <= 1'b0;
    s_tdata  <= IN_TDATA_W'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  // hold off the sender until every outstanding request has its result
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic sample_t next_sample(burst_shape_e shape);
    case (shape)
      SHAPE_NARROW:  return sample_t'(int'($urandom_range(0, 16)) - 8);
      SHAPE_RISING: begin
        ramp_value += $urandom_range(0, 3);
        return sample_t'(ramp_value);
      end
      SHAPE_FALLING: begin
        ramp_value -= $urandom_range(0, 3);
        return sample_t'(ramp_value);
      end
      SHAPE_EXTREME: begin
        case ($urandom_range(0, 5))
          0:       return -16'sd32768;
          1:       return 16'sd32767;
          2:       return 16'sd0;
          3:       return -16'sd1;
          4:       return -16'sd32767;
          default: return 16'sd32766;
        endcase
      end
      default:       return sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int           sent;
    int           burst_len;
    bit           paused_midway;
    burst_shape_e shape;
    sent          = 0;
    paused_midway = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_samples[i]) send_sample(directed_samples[i]);
    drain_results();

    while (sent < RANDOM_ITEMS) begin
      burst_len  = $urandom_range(1, 24);
      shape      = burst_shape_e'($urandom_range(0, 4));
      ramp_value = int'(sample_t'($urandom_range(0, 65535)));
      for (int i = 0; i < burst_len && sent < RANDOM_ITEMS; i++) begin
        send_sample(next_sample(shape));
        sent++;
      end
      if (!paused_midway && sent >= RANDOM_ITEMS / 2) begin
        paused_midway = 1'b1;
        drain_results();
      end else if ($urandom_range(0, 3) != 0) begin
        idle_cycles($urandom_range(1, 6));
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("ran %0d samples through the median store, %0d refused once it was full",
             sb.accepted, sb.refused);
    $display("checked %0d results against the two-half prediction", sb.checked);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
src/rmt_pkg.sv
src/rmt_cell.sv
src/rmt_row.sv
src/running_median_tracker_top.sv
tb/tb_running_median_tracker_top.sv
